// File: src/tcpb_pkg.sv
// Package for the Telnet com-port baud parser: parse modes, protocol byte codes,
// and the state and result structs shared by the parse core and the top level.
// No dependencies.
package tcpb_pkg;

  localparam logic [7:0] TN_IAC      = 8'd255;
  localparam logic [7:0] TN_SB       = 8'd250;
  localparam logic [7:0] TN_SE       = 8'd240;
  localparam logic [7:0] COM_PORT_OPT = 8'd44;
  localparam logic [7:0] SET_BAUD    = 8'd1;

  localparam int unsigned CountW = 3;
  localparam int unsigned ShiftW = 24;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_IAC     = 3'd1,
    MODE_SB      = 3'd2,
    MODE_OPTION  = 3'd3,
    MODE_BAUD    = 3'd4,
    MODE_WAIT_SE = 3'd5
  } mode_e;

  typedef enum logic {
    KIND_SERIAL = 1'b0,
    KIND_BAUD   = 1'b1
  } kind_e;

  typedef struct packed {
    mode_e              mode;
    logic [CountW-1:0]  count;
    logic [ShiftW-1:0]  shift;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  serial_byte;
    logic [31:0] baud_value;
  } parse_result_t;

endpackage

// File: src/tcpb_parse.sv
// Combinational parse step: one byte and the current parser state give the
// next state and at most one result. Depends on tcpb_pkg.
module tcpb_parse
  import tcpb_pkg::*;
(
  input  logic [7:0]    data_byte_i,
  input  parse_state_t  state_i,
  output parse_state_t  state_o,
  output parse_result_t result_o
);

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, kind: KIND_SERIAL, serial_byte: 8'd0, baud_value: 32'd0};

    unique case (state_i.mode)
      MODE_IAC: begin
        if (data_byte_i == TN_SB) begin
          state_o.mode = MODE_SB;
        end else begin
          state_o.mode = MODE_NORMAL;
          if (data_byte_i == TN_IAC) begin
            result_o.valid       = 1'b1;
            result_o.serial_byte = data_byte_i;
          end
        end
      end
      MODE_SB: begin
        if (data_byte_i == COM_PORT_OPT) begin
          state_o.mode  = MODE_OPTION;
          state_o.count = '0;
          state_o.shift = '0;
        end else begin
          state_o.mode = MODE_NORMAL;
        end
      end
      MODE_OPTION: begin
        if (data_byte_i == SET_BAUD) begin
          state_o.mode = MODE_BAUD;
        end else if (data_byte_i == TN_IAC) begin
          state_o.mode = MODE_WAIT_SE;
        end
      end
      MODE_BAUD: begin
        if (data_byte_i == TN_IAC) begin
          state_o.mode = MODE_WAIT_SE;
        end else if (state_i.count >= CountW'(3)) begin
          // Fourth byte completes the big-endian rate.
          result_o.valid      = 1'b1;
          result_o.kind       = KIND_BAUD;
          result_o.baud_value = {state_i.shift, data_byte_i};
          state_o.count       = '0;
          state_o.shift       = '0;
          state_o.mode        = MODE_WAIT_SE;
        end else begin
          state_o.shift = {state_i.shift[ShiftW-9:0], data_byte_i};
          state_o.count = state_i.count + CountW'(1);
        end
      end
      MODE_WAIT_SE: begin
        if (data_byte_i == TN_SE) begin
          state_o.mode = MODE_NORMAL;
        end
      end
      default: begin
        // Normal data mode; unused codes behave the same way.
        if (data_byte_i == TN_IAC) begin
          state_o.mode = MODE_IAC;
        end else begin
          state_o.mode         = MODE_NORMAL;
          result_o.valid       = 1'b1;
          result_o.serial_byte = data_byte_i;
        end
      end
    endcase
  end

endmodule

// File: src/telnet_com_port_baud_parser.sv
// Telnet com-port baud parser top level: input register, parser state and
// result register around the tcpb_parse step. Depends on tcpb_pkg, tcpb_parse.
//
// Usage: the input channel carries one network byte per transfer on
// data_byte_i (in_valid_i / in_stall_o). The output channel carries at most
// one result per input byte (out_valid_o / out_stall_i): kind_o = 0 gives a
// byte for the serial line on serial_byte_o, kind_o = 1 gives a requested
// baud rate on baud_value_o. The field that does not apply reads as zero.
// IAC IAC gives byte 255; other commands and subnegotiations give only baud rates.
//
// A byte taken into the input register is parsed by tcpb_parse into the result
// register, which drives the output ports.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// combinational parse step between the input register and the result register.
// Reset (rst_ni low) returns the parser to normal data mode, clears the
// gathered baud bytes and empties both registers.
// When the receiver stalls, the result register holds its transfer; the
// input register still takes one more byte, and then in_stall_o rises until
// the result is taken.
module telnet_com_port_baud_parser
  import tcpb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  serial_byte_o,
  output logic [31:0] baud_value_o
);

  // Input register stage.
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;

  // Parser state.
  parse_state_t state_q, state_d, state_next;
  parse_result_t step_res;

  // Result register.
  logic        out_vld_q, out_vld_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  serial_q, serial_d;
  logic [31:0] baud_q, baud_d;

  logic out_free;
  logic advance;
  logic in_take;

  tcpb_parse u_parse (
    .data_byte_i (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_next),
    .result_o    (step_res)
  );

  // The result register is free when empty or when its transfer completes now.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    state_d   = state_q;
    out_vld_d = out_vld_q;
    kind_d    = kind_q;
    serial_d  = serial_q;
    baud_d    = baud_q;

    if (out_free) begin
      out_vld_d = 1'b0;
    end
    if (advance) begin
      state_d   = state_next;
      out_vld_d = step_res.valid;
      kind_d    = step_res.kind;
      serial_d  = step_res.serial_byte;
      baud_d    = step_res.baud_value;
      in_vld_d  = 1'b0;
    end
    if (in_take) begin
      in_vld_d  = 1'b1;
      in_byte_d = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q   <= '{mode: MODE_NORMAL, count: '0, shift: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    kind_q    <= kind_d;
    serial_q  <= serial_d;
    baud_q    <= baud_d;
  end

  assign out_valid_o   = out_vld_q;
  assign kind_o        = kind_q;
  assign serial_byte_o = serial_q;
  assign baud_value_o  = baud_q;

`ifndef NO_ASSERTIONS
  // The gathered-byte count never passes three.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.count <= CountW'(3))
    else $error("baud byte count out of range");

  // A finished baud rate always leaves the parser waiting for the end marker.
  a_baud_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && step_res.valid && step_res.kind == KIND_BAUD)
      |=> state_q.mode == MODE_WAIT_SE)
    else $error("baud result without move to wait-for-SE");

  // The field that does not belong to the result kind reads as zero.
  a_unused_field_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o ? (serial_byte_o == 8'd0) : (baud_value_o == 32'd0)))
    else $error("unused result field not zero");

  // Input is only held off while a byte waits behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled without a blocked result");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for telnet_com_port_baud_parser: directed Telnet
// sequences, then random traffic under several idle and stall mixes.
// Depends on tcpb_pkg and the telnet_com_port_baud_parser RTL.
module tb;
  import tcpb_pkg::*;

  // Telnet command bytes that the package does not name.
  localparam logic [7:0] TN_WILL = 8'd251;
  localparam logic [7:0] TN_DONT = 8'd254;
  localparam logic [7:0] TN_NOP  = 8'd241;
  localparam logic [7:0] OPT_TERMINAL_TYPE = 8'd24;
  localparam logic [7:0] SET_CONTROL = 8'd5;

  // A stretch of this many cycles with no transfer on either channel means the
  // block has hung.
  localparam int unsigned HangLimit = 2000;
  // Cycles to wait after the last expected result has been taken.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems = 200;

  // One write toward the serial port: either a data byte or a new baud rate.
  typedef struct {
    kind_e       kind;
    logic [7:0]  serial_byte;
    logic [31:0] baud_value;
  } port_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  serial_byte_o;
  logic [31:0] baud_value_o;

  // Predicted parser state, updated once per input transfer.
  mode_e             pred_mode = MODE_NORMAL;
  logic [CountW-1:0] pred_count = '0;
  logic [ShiftW-1:0] pred_shift = '0;

  // Port writes that the parser owes us, oldest first.
  port_event_t expected_port_events[$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_that_matter = 0;
  int unsigned serial_checked = 0;
  int unsigned baud_checked = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  telnet_com_port_baud_parser u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .serial_byte_o (serial_byte_o),
    .baud_value_o  (baud_value_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Advances the predicted parser by one network byte. Returns 1 when the
  // byte causes a port write, which is then placed in ev.
  function automatic bit parse_telnet_byte(input logic [7:0] c, output port_event_t ev);
    bit emits;
    emits = 1'b0;
    ev.kind = KIND_SERIAL;
    ev.serial_byte = 8'h00;
    ev.baud_value = 32'h0;
    case (pred_mode)
      MODE_IAC: begin
        if (c == TN_SB) begin
          pred_mode = MODE_SB;
        end else begin
          // A doubled IAC is a literal 255; any other command byte is dropped.
          pred_mode = MODE_NORMAL;
          if (c == TN_IAC) begin
            ev.serial_byte = c;
            emits = 1'b1;
          end
        end
      end
      MODE_SB: begin
        if (c == COM_PORT_OPT) begin
          pred_mode = MODE_OPTION;
          pred_count = '0;
          pred_shift = '0;
        end else begin
          pred_mode = MODE_NORMAL;
        end
      end
      MODE_OPTION: begin
        if (c == SET_BAUD) begin
          pred_mode = MODE_BAUD;
        end else if (c == TN_IAC) begin
          pred_mode = MODE_WAIT_SE;
        end
      end
      MODE_BAUD: begin
        if (c == TN_IAC) begin
          // The partial rate is abandoned.
          pred_mode = MODE_WAIT_SE;
        end else if (pred_count >= 3) begin
          ev.kind = KIND_BAUD;
          ev.baud_value = {pred_shift, c};
          emits = 1'b1;
          pred_count = '0;
          pred_shift = '0;
          pred_mode = MODE_WAIT_SE;
        end else begin
          pred_shift = {pred_shift[ShiftW-9:0], c};
          pred_count = pred_count + 1'b1;
        end
      end
      MODE_WAIT_SE: begin
        if (c == TN_SE) begin
          pred_mode = MODE_NORMAL;
        end
      end
      default: begin
        if (c == TN_IAC) begin
          pred_mode = MODE_IAC;
        end else begin
          pred_mode = MODE_NORMAL;
          ev.serial_byte = c;
          emits = 1'b1;
        end
      end
    endcase
    return emits;
  endfunction

  // Sends one network byte and waits for its transfer. The valid line is
  // left high afterwards, so back-to-back bytes never drop it in between;
  // the next call or the end of the test decides whether it falls.
  task automatic send_byte(input logic [7:0] b);
    port_event_t ev;
    logic [29:0] state_before;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    state_before = {pred_mode, pred_count, pred_shift};
    if (parse_telnet_byte(b, ev)) begin
      expected_port_events.push_back(ev);
      bytes_that_matter++;
    end else if (state_before != {pred_mode, pred_count, pred_shift}) begin
      bytes_that_matter++;
    end
    bytes_sent++;
  endtask

  task automatic send_baud_command(input logic [31:0] rate);
    send_byte(TN_IAC);
    send_byte(TN_SB);
    send_byte(COM_PORT_OPT);
    send_byte(SET_BAUD);
    for (int i = 3; i >= 0; i--) begin
      send_byte(rate[8*i +: 8]);
    end
    send_byte(TN_IAC);
    send_byte(TN_SE);
  endtask

  // A rate whose bytes never hit IAC, so the command always completes.
  function automatic logic [31:0] clean_rate(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r[8*i +: 8] == TN_IAC) begin
        r[8*i +: 8] = 8'($urandom_range(254));
      end
    end
    return r;
  endfunction

  // Receiver side: stall at random and check every result transfer against
  // the oldest expected port write.
  always @(posedge clk_i) begin
    port_event_t exp_ev;
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_port_events.size() == 0) begin
        $error("unexpected result: kind %0d serial_byte 0x%02h baud_value %0d",
               kind_o, serial_byte_o, baud_value_o);
        mismatches++;
      end else begin
        exp_ev = expected_port_events.pop_front();
        if (kind_o !== exp_ev.kind) begin
          $error("kind: expected %0d, got %0d", exp_ev.kind, kind_o);
          mismatches++;
        end
        if (serial_byte_o !== exp_ev.serial_byte) begin
          $error("serial_byte: expected 0x%02h, got 0x%02h", exp_ev.serial_byte,
                 serial_byte_o);
          mismatches++;
        end
        if (baud_value_o !== exp_ev.baud_value) begin
          $error("baud_value: expected %0d, got %0d", exp_ev.baud_value, baud_value_o);
          mismatches++;
        end
        if (exp_ev.kind == KIND_BAUD) begin
          baud_checked++;
        end else begin
          serial_checked++;
        end
      end
    end
  end

  // Hang detector: counts cycles without a transfer on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HangLimit) begin
      $display("timeout: no transfer for %0d cycles", HangLimit);
      $display("[telnet_com_port_baud_parser] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Plain data passes through, a doubled IAC becomes one literal 255, and the
  // option byte after WILL is treated as ordinary data.
  task automatic test_plain_and_escapes();
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(TN_IAC);
    send_byte(TN_IAC);
    send_byte(TN_IAC);
    send_byte(TN_WILL);
    send_byte(COM_PORT_OPT);
  endtask

  // Largest rate that can be expressed without an IAC byte, closed by a bare
  // SE rather than IAC SE.
  task automatic test_baud_extreme();
    send_byte(TN_IAC);
    send_byte(TN_SB);
    send_byte(COM_PORT_OPT);
    send_byte(SET_BAUD);
    repeat (4) send_byte(8'hFE);
    send_byte(TN_SE);
  endtask

  task automatic test_subnegotiation_corners();
    // A subnegotiation for another option drops straight back to data mode.
    send_byte(TN_IAC);
    send_byte(TN_SB);
    send_byte(OPT_TERMINAL_TYPE);
    // Another com-port sub-command skips to IAC, and while waiting for SE
    // even a further IAC is dropped.
    send_byte(TN_IAC);
    send_byte(TN_SB);
    send_byte(COM_PORT_OPT);
    send_byte(SET_CONTROL);
    send_byte(TN_IAC);
    send_byte(TN_IAC);
    send_byte(TN_SE);
    // IAC in the middle of a rate throws away the gathered bytes.
    send_byte(TN_IAC);
    send_byte(TN_SB);
    send_byte(COM_PORT_OPT);
    send_byte(SET_BAUD);
    send_byte(8'h12);
    send_byte(TN_IAC);
    send_byte(TN_SE);
  endtask

  // The sender goes quiet until every owed result has been taken, then
  // picks up again.
  task automatic test_drain_pause();
    send_baud_command(clean_rate($urandom));
    send_byte(8'($urandom_range(254)));
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_port_events.size() != 0);
    send_byte(8'($urandom_range(254)));
  endtask

  // Random Telnet traffic, mostly well-formed sequences with random content,
  // the rest noise and truncated commands. Runs until enough bytes have had
  // an effect on the parser.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned target);
    int unsigned pick;
    int unsigned goal;
    logic [7:0] b;
    logic [7:0] specials[5];
    specials = '{TN_IAC, TN_SB, TN_SE, COM_PORT_OPT, SET_BAUD};
    tx_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    goal = bytes_that_matter + target;
    while (bytes_that_matter < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // Data run; 255 is escaped as a real sender would.
        repeat ($urandom_range(6, 1)) begin
          b = 8'($urandom);
          if (b == TN_IAC) send_byte(TN_IAC);
          send_byte(b);
        end
      end else if (pick < 60) begin
        case ($urandom_range(3))
          0: send_baud_command(clean_rate({$urandom_range(3) == 0 ? 24'h0 : 24'($urandom),
                                           8'($urandom)}));
          1: send_baud_command(32'($urandom_range(921600, 300)));
          2: send_baud_command(32'h0);
          default: send_baud_command(clean_rate($urandom));
        endcase
      end else if (pick < 70) begin
        // Two-byte command, then a byte that passes as data unless the command is SB.
        send_byte(TN_IAC);
        send_byte(8'($urandom_range(TN_DONT, TN_NOP)));
        send_byte(8'($urandom_range(254)));
      end else if (pick < 78) begin
        // Another com-port sub-command with a random body.
        send_byte(TN_IAC);
        send_byte(TN_SB);
        send_byte(COM_PORT_OPT);
        do b = 8'($urandom); while (b == SET_BAUD);
        send_byte(b);
        repeat ($urandom_range(3)) send_byte(8'($urandom));
        send_byte(TN_IAC);
        send_byte(TN_SE);
      end else if (pick < 84) begin
        send_byte(TN_IAC);
        send_byte(TN_SB);
        do b = 8'($urandom); while (b == COM_PORT_OPT);
        send_byte(b);
      end else if (pick < 92) begin
        // Rate cut short by IAC SE.
        send_byte(TN_IAC);
        send_byte(TN_SB);
        send_byte(COM_PORT_OPT);
        send_byte(SET_BAUD);
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(254)));
        send_byte(TN_IAC);
        send_byte(TN_SE);
      end else begin
        repeat ($urandom_range(8, 1)) begin
          if ($urandom_range(1) == 0) begin
            send_byte(specials[$urandom_range(4)]);
          end else begin
            send_byte(8'($urandom));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_and_escapes();
    test_baud_extreme();
    test_subnegotiation_corners();

    test_random_traffic(0, 0, PhaseItems);
    test_drain_pause();
    test_random_traffic(51, 0, PhaseItems);
    test_random_traffic(0, 51, PhaseItems);
    test_drain_pause();
    test_random_traffic(26, 26, PhaseItems);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_port_events.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (expected_port_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_port_events.size());
      mismatches++;
    end
    $display("Fed %0d Telnet bytes (%0d with an effect) through four idle/stall mixes;",
             bytes_sent, bytes_that_matter);
    $display("checked %0d serial bytes and %0d baud rate commands.",
             serial_checked, baud_checked);
    if (mismatches == 0) begin
      $display("[telnet_com_port_baud_parser] OK");
    end else begin
      $display("[telnet_com_port_baud_parser] ERROR");
    end
    $finish;
  end

endmodule
